// File: rtl/tbo_pkg.sv
// Shared register indexes and the axis projection test for the triangle/box overlap core.
package tbo_pkg;

	localparam int SEP_W = 192;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER_X = 3'd0,
		REG_LOWER_Y = 3'd1,
		REG_LOWER_Z = 3'd2,
		REG_UPPER_X = 3'd3,
		REG_UPPER_Y = 3'd4,
		REG_UPPER_Z = 3'd5,
		REG_MARGIN  = 3'd6
	} cfg_reg_t;

	function automatic logic axis_separates(
		input logic signed [SEP_W-1:0] p0,
		input logic signed [SEP_W-1:0] p1,
		input logic signed [SEP_W-1:0] p2,
		input logic signed [SEP_W-1:0] rad
	);
		logic signed [SEP_W-1:0] lo;
		logic signed [SEP_W-1:0] hi;
		lo = p0;
		hi = p0;
		if (p1 < lo) lo = p1;
		if (p2 < lo) lo = p2;
		if (p1 > hi) hi = p1;
		if (p2 > hi) hi = p2;
		return (lo > rad) || ((-hi) > rad);
	endfunction

endpackage

// File: rtl/tbo_edge_axis.sv
// Three-stage projection test on one box-normal-cross-edge axis.
module tbo_edge_axis import tbo_pkg::*; #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic signed [W+1:0] pa [3],
	input  logic signed [W+1:0] pb [3],
	input  logic signed [W:0]   fa,
	input  logic signed [W:0]   fb,
	input  logic signed [W+1:0] ea,
	input  logic signed [W+1:0] eb,
	output logic                ok
);

	localparam int FW = W + 1;
	localparam int PW = 2 * W + 4;
	localparam int SW = PW + 1;

	logic [FW-1:0]          abs_fa;
	logic [FW-1:0]          abs_fb;
	logic signed [PW-1:0]   mp_s1 [3];
	logic signed [PW-1:0]   mn_s1 [3];
	logic signed [PW-1:0]   ra_s1;
	logic signed [PW-1:0]   rb_s1;
	logic signed [SW-1:0]   p_s2 [3];
	logic signed [SW-1:0]   rad_s2;

	assign abs_fa = fa[FW-1] ? FW'(-fa) : FW'(fa);
	assign abs_fb = fb[FW-1] ? FW'(-fb) : FW'(fb);

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			mp_s1[j] <= PW'(pb[j]) * PW'(fa);
			mn_s1[j] <= PW'(pa[j]) * PW'(fb);
			p_s2[j]  <= SW'(mp_s1[j]) - SW'(mn_s1[j]);
		end
		ra_s1  <= PW'(ea) * PW'($signed({1'b0, abs_fb}));
		rb_s1  <= PW'(eb) * PW'($signed({1'b0, abs_fa}));
		rad_s2 <= SW'(ra_s1) + SW'(rb_s1);
		ok     <= !axis_separates(SEP_W'(p_s2[0]), SEP_W'(p_s2[1]), SEP_W'(p_s2[2]),
			SEP_W'(rad_s2));
	end

endmodule

// File: rtl/tbo_normal_axis.sv
// Seven-stage projection test on the triangle normal axis.
module tbo_normal_axis import tbo_pkg::*; #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic signed [W:0]   f0 [3],
	input  logic signed [W:0]   f1 [3],
	input  logic signed [W+1:0] tv [3][3],
	input  logic signed [W+1:0] e [3],
	output logic                ok
);

	localparam int FW  = W + 1;
	localparam int TW  = W + 2;
	localparam int MW  = 2 * FW;
	localparam int NW  = 2 * FW + 1;
	localparam int LW  = NW / 2;
	localparam int HW  = NW - LW;
	localparam int QW  = TW + HW + 2;
	localparam int FPW = TW + NW + 2;
	localparam int DW  = FPW + 2;

	logic signed [MW-1:0]  m_s1 [6];
	logic signed [TW-1:0]  tv_s1 [3][3];
	logic signed [NW-1:0]  n_s2 [3];
	logic signed [TW-1:0]  tv_s2 [3][3];
	logic signed [NW-1:0]  n_s3 [3];
	logic [NW-1:0]         an_s3 [3];
	logic signed [TW-1:0]  tv_s3 [3][3];
	logic signed [QW-1:0]  ph_s4 [3][3];
	logic signed [QW-1:0]  pl_s4 [3][3];
	logic signed [QW-1:0]  rh_s4 [3];
	logic signed [QW-1:0]  rl_s4 [3];
	logic signed [FPW-1:0] q_s5 [3][3];
	logic signed [FPW-1:0] r_s5 [3];
	logic signed [DW-1:0]  p_s6 [3];
	logic signed [DW-1:0]  rad_s6;

	always_ff @(posedge clk) begin
		m_s1[0] <= MW'(f0[1]) * MW'(f1[2]);
		m_s1[1] <= MW'(f0[2]) * MW'(f1[1]);
		m_s1[2] <= MW'(f0[2]) * MW'(f1[0]);
		m_s1[3] <= MW'(f0[0]) * MW'(f1[2]);
		m_s1[4] <= MW'(f0[0]) * MW'(f1[1]);
		m_s1[5] <= MW'(f0[1]) * MW'(f1[0]);
		tv_s1   <= tv;
		for (int i = 0; i < 3; i++) begin
			n_s2[i]  <= NW'(m_s1[2*i]) - NW'(m_s1[2*i+1]);
			n_s3[i]  <= n_s2[i];
			an_s3[i] <= n_s2[i][NW-1] ? NW'(-n_s2[i]) : NW'(n_s2[i]);
			rh_s4[i] <= QW'(e[i]) * QW'($signed({1'b0, an_s3[i][NW-1:LW]}));
			rl_s4[i] <= QW'(e[i]) * QW'($signed({1'b0, an_s3[i][LW-1:0]}));
			r_s5[i]  <= (FPW'(rh_s4[i]) <<< LW) + FPW'(rl_s4[i]);
			for (int j = 0; j < 3; j++) begin
				ph_s4[j][i] <= QW'(tv_s3[j][i]) * QW'($signed(n_s3[i][NW-1:LW]));
				pl_s4[j][i] <= QW'(tv_s3[j][i]) * QW'($signed({1'b0, n_s3[i][LW-1:0]}));
				q_s5[j][i]  <= (FPW'(ph_s4[j][i]) <<< LW) + FPW'(pl_s4[j][i]);
			end
		end
		tv_s2 <= tv_s1;
		tv_s3 <= tv_s2;
		for (int j = 0; j < 3; j++) begin
			p_s6[j] <= DW'(q_s5[j][0]) + DW'(q_s5[j][1]) + DW'(q_s5[j][2]);
		end
		rad_s6 <= DW'(r_s5[0]) + DW'(r_s5[1]) + DW'(r_s5[2]);
		ok     <= !axis_separates(SEP_W'(p_s6[0]), SEP_W'(p_s6[1]), SEP_W'(p_s6[2]),
			SEP_W'(rad_s6));
	end

endmodule

// File: rtl/triangle_box_overlap_test_core.sv
// Top level: triangle versus box separating-axis overlap test, fully pipelined.
//
// Usage:
//   Load the box bounds and the shrink margin through the write port (wr_en,
//   wr_index, wr_data) while no triangle is in flight; writes take effect at
//   once and unused indexes are ignored.
//   Present a triangle on v0_*..v2_* with start high; the word is taken at
//   every clock edge where start is high, since busy stays low.
//   The result appears on overlap with done high for one cycle, after the
//   input registers, the normal-axis stages and the output register.
//   One triangle enters per cycle; the latency is set by the normal-axis path
//   (two chained multiply stages with a split wide product and its adds).
//   Results leave in order and the receiver cannot stall; nothing is held
//   back. Reset clears the box registers to zero and empties the pipeline,
//   so no done pulse follows reset until a new word is taken.
module triangle_box_overlap_test_core import tbo_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] v0_x,
	input  logic signed [COORD_WIDTH-1:0] v0_y,
	input  logic signed [COORD_WIDTH-1:0] v0_z,
	input  logic signed [COORD_WIDTH-1:0] v1_x,
	input  logic signed [COORD_WIDTH-1:0] v1_y,
	input  logic signed [COORD_WIDTH-1:0] v1_z,
	input  logic signed [COORD_WIDTH-1:0] v2_x,
	input  logic signed [COORD_WIDTH-1:0] v2_y,
	input  logic signed [COORD_WIDTH-1:0] v2_z,
	input  logic                          wr_en,
	input  logic [CFG_IDX_W-1:0]          wr_index,
	input  logic [COORD_WIDTH-1:0]        wr_data,
	output logic                          done,
	output logic                          overlap
);

	localparam int W        = COORD_WIDTH;
	localparam int TW       = W + 2;
	localparam int FW       = W + 1;
	localparam int EW       = W + 2;
	localparam int NORM_LAT = 7;
	localparam int EDGE_LAT = 3;
	localparam int FACE_LAT = 1;
	localparam int EDGE_DLY = NORM_LAT - EDGE_LAT;
	localparam int FACE_DLY = NORM_LAT - FACE_LAT;
	localparam int OUT_LAT  = NORM_LAT + 2;

	logic signed [W-1:0]  lower_q [3];
	logic signed [W-1:0]  upper_q [3];
	logic [W-2:0]         margin_q;

	logic signed [W-1:0]  vin [3][3];
	logic signed [W:0]    c2 [3];
	logic signed [EW-1:0] e [3];
	logic signed [TW-1:0] tv_n [3][3];
	logic signed [FW-1:0] f_n [3][3];
	logic signed [TW-1:0] tv_s1 [3][3];
	logic signed [FW-1:0] f_s1 [3][3];
	logic [NORM_LAT:0]    vld_q;
	logic [2:0]           face_sep;
	logic                 face_s2;
	logic [FACE_DLY-1:0]  face_q;
	logic [8:0]           edge_ok;
	logic [8:0]           edge_q [EDGE_DLY];
	logic                 norm_ok;
	logic                 accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lower_q[i] <= '0;
				upper_q[i] <= '0;
			end
			margin_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOWER_X: lower_q[0] <= wr_data;
				REG_LOWER_Y: lower_q[1] <= wr_data;
				REG_LOWER_Z: lower_q[2] <= wr_data;
				REG_UPPER_X: upper_q[0] <= wr_data;
				REG_UPPER_Y: upper_q[1] <= wr_data;
				REG_UPPER_Z: upper_q[2] <= wr_data;
				REG_MARGIN:  margin_q   <= wr_data[W-2:0];
				default: ;
			endcase
		end
	end

	assign vin[0][0] = v0_x;
	assign vin[0][1] = v0_y;
	assign vin[0][2] = v0_z;
	assign vin[1][0] = v1_x;
	assign vin[1][1] = v1_y;
	assign vin[1][2] = v1_z;
	assign vin[2][0] = v2_x;
	assign vin[2][1] = v2_y;
	assign vin[2][2] = v2_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c2[i] = {lower_q[i][W-1], lower_q[i]} + {upper_q[i][W-1], upper_q[i]};
			e[i]  = {{2{upper_q[i][W-1]}}, upper_q[i]} - {{2{lower_q[i][W-1]}}, lower_q[i]}
				- {2'b00, margin_q, 1'b0};
			for (int j = 0; j < 3; j++) begin
				tv_n[j][i] = {vin[j][i][W-1], vin[j][i], 1'b0} - {c2[i][W], c2[i]};
				f_n[j][i]  = {vin[(j == 2) ? 0 : j + 1][i][W-1], vin[(j == 2) ? 0 : j + 1][i]}
					- {vin[j][i][W-1], vin[j][i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		tv_s1 <= tv_n;
		f_s1  <= f_n;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			face_sep[i] = axis_separates(SEP_W'(tv_s1[0][i]), SEP_W'(tv_s1[1][i]),
				SEP_W'(tv_s1[2][i]), SEP_W'(e[i]));
		end
	end

	genvar k, a;
	generate
		for (k = 0; k < 3; k++) begin : g_edge
			for (a = 0; a < 3; a++) begin : g_axis
				localparam int C1 = (a + 1) % 3;
				localparam int C2 = (a + 2) % 3;
				logic signed [TW-1:0] pa [3];
				logic signed [TW-1:0] pb [3];
				for (genvar j = 0; j < 3; j++) begin : g_vtx
					assign pa[j] = tv_s1[j][C1];
					assign pb[j] = tv_s1[j][C2];
				end
				tbo_edge_axis #(.W(W)) u_edge (
					.clk (clk),
					.pa  (pa),
					.pb  (pb),
					.fa  (f_s1[k][C1]),
					.fb  (f_s1[k][C2]),
					.ea  (e[C1]),
					.eb  (e[C2]),
					.ok  (edge_ok[k*3+a])
				);
			end
		end
	endgenerate

	tbo_normal_axis #(.W(W)) u_normal (
		.clk (clk),
		.f0  (f_s1[0]),
		.f1  (f_s1[1]),
		.tv  (tv_s1),
		.e   (e),
		.ok  (norm_ok)
	);

	always_ff @(posedge clk) begin
		face_s2   <= ~|face_sep;
		face_q[0] <= face_s2;
		for (int i = 1; i < FACE_DLY; i++) begin
			face_q[i] <= face_q[i-1];
		end
		edge_q[0] <= edge_ok;
		for (int i = 1; i < EDGE_DLY; i++) begin
			edge_q[i] <= edge_q[i-1];
		end
		overlap <= norm_ok && (&edge_q[EDGE_DLY-1]) && face_q[FACE_DLY-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[NORM_LAT-1:0], accept};
			done  <= vld_q[NORM_LAT];
		end
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##OUT_LAT done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, OUT_LAT))
		else $error("result without an accepted word");

	a_pipe_matches: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[EDGE_LAT] |-> $past(accept, EDGE_LAT + 1))
		else $error("valid pipeline out of step");

endmodule
